FILE: src/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int HUE_FRAC_BITS = 6;
  localparam int CH_W = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 17;

  // One quotient bit per cell; the saturation quotient needs 18 bits before rounding.
  localparam int NSTEP = 18;

  // The hue quotient carries one extra fraction bit for round to nearest.
  localparam int HUE_K = HUE_FRAC_BITS + 1;
  localparam int HT_W = HUE_K + 10;

  localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(1) << 16;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_e;

  typedef struct packed {
    logic [CH_W-1:0]  den;
    logic [CH_W-1:0]  rem;
    logic [NSTEP-1:0] nq;
  } div_lane_t;

  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic            mz;
    logic            dz;
    logic            neg;
    sect_e           sect;
  } side_t;

  typedef struct packed {
    logic      valid;
    side_t     side;
    div_lane_t sat;
    div_lane_t hue;
  } stage_t;

endpackage

FILE: src/rgbhsv_pix_if.sv
interface rgbhsv_pix_if import rgbhsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: src/rgbhsv_hsv_if.sv
interface rgbhsv_hsv_if import rgbhsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_angle;
  logic [SAT_W-1:0] saturation_frac;
  logic [CH_W-1:0]  value_level;

  modport source (output valid, hue_angle, saturation_frac, value_level, input ready);
  modport sink (input valid, hue_angle, saturation_frac, value_level, output ready);
endinterface

FILE: src/rgbhsv_front.sv
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  output stage_t          stage_o
);

  localparam int PROD_W = CH_W + 6;
  localparam int HN_W = NSTEP + CH_W;

  sect_e             sect;
  logic [CH_W-1:0]   mx;
  logic [CH_W-1:0]   mn;
  logic [CH_W-1:0]   dif;
  logic [CH_W:0]     x;
  logic [CH_W-1:0]   ax;
  logic [PROD_W-1:0] prod;
  logic [HN_W-1:0]   hn;
  stage_t            stage_d;
  logic              valid_q;
  side_t             side_q;
  div_lane_t         sat_q;
  div_lane_t         hue_q;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sect = SECT_RED;
    end else if (green_i >= blue_i) begin
      sect = SECT_GREEN;
    end else begin
      sect = SECT_BLUE;
    end

    mn = red_i;
    if (green_i < mn) begin
      mn = green_i;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end

    unique case (sect)
      SECT_RED: begin
        mx = red_i;
        x  = {1'b0, green_i} - {1'b0, blue_i};
      end
      SECT_GREEN: begin
        mx = green_i;
        x  = {1'b0, blue_i} - {1'b0, red_i};
      end
      SECT_BLUE: begin
        mx = blue_i;
        x  = {1'b0, red_i} - {1'b0, green_i};
      end
      default: begin
        mx = red_i;
        x  = '0;
      end
    endcase

    dif  = mx - mn;
    ax   = x[CH_W] ? (~x[CH_W-1:0] + CH_W'(1)) : x[CH_W-1:0];
    prod = PROD_W'(ax) * PROD_W'(60);
    hn   = HN_W'(prod) << HUE_K;

    stage_d.valid     = valid_i;
    stage_d.side.mx   = mx;
    stage_d.side.mz   = (mx == '0);
    stage_d.side.dz   = (dif == '0);
    stage_d.side.neg  = x[CH_W];
    stage_d.side.sect = sect;

    // The top dividend bits already sit in the remainder, since they are below the divisor.
    stage_d.sat.den = mx;
    stage_d.sat.rem = {1'b0, dif[CH_W-1:1]};
    stage_d.sat.nq  = {dif[0], {(NSTEP-1){1'b0}}};
    stage_d.hue.den = dif;
    stage_d.hue.rem = hn[NSTEP+CH_W-1:NSTEP];
    stage_d.hue.nq  = hn[NSTEP-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= stage_d.side;
      sat_q  <= stage_d.sat;
      hue_q  <= stage_d.hue;
    end
  end

  assign stage_o = '{valid: valid_q, side: side_q, sat: sat_q, hue: hue_q};

endmodule

FILE: src/rgbhsv_cell.sv
module rgbhsv_cell import rgbhsv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  stage_t stage_i,
  output stage_t stage_o
);

  // One restoring division step: bring down the next dividend bit and try to subtract.
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t r;
    logic [CH_W:0] t;
    logic ge;
    t  = {l.rem, l.nq[NSTEP-1]};
    ge = (t >= {1'b0, l.den});
    r  = l;
    r.rem = ge ? CH_W'(t - {1'b0, l.den}) : t[CH_W-1:0];
    r.nq  = {l.nq[NSTEP-2:0], ge};
    return r;
  endfunction

  stage_t    stage_d;
  logic      valid_q;
  side_t     side_q;
  div_lane_t sat_q;
  div_lane_t hue_q;

  always_comb begin
    stage_d     = stage_i;
    stage_d.sat = div_step(stage_i.sat);
    stage_d.hue = div_step(stage_i.hue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= stage_d.side;
      sat_q  <= stage_d.sat;
      hue_q  <= stage_d.hue;
    end
  end

  assign stage_o = '{valid: valid_q, side: side_q, sat: sat_q, hue: hue_q};

`ifndef ASSERT_OFF
  a_sat_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !side_q.mz |-> sat_q.rem < sat_q.den)
    else $error("saturation remainder not below divisor");

  a_hue_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !side_q.dz |-> hue_q.rem < hue_q.den)
    else $error("hue remainder not below divisor");
`endif

endmodule

FILE: src/rgbhsv_back.sv
module rgbhsv_back import rgbhsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  stage_t           stage_i,
  output logic             valid_o,
  output logic [HUE_W-1:0] hue_angle_o,
  output logic [SAT_W-1:0] saturation_frac_o,
  output logic [CH_W-1:0]  value_level_o
);

  localparam logic [HT_W-1:0] HUE_FULL = HT_W'(360) << HUE_FRAC_BITS;
  localparam logic [HT_W-1:0] HUE_OFF120 = HT_W'(120) << HUE_K;
  localparam logic [HT_W-1:0] HUE_OFF240 = HT_W'(240) << HUE_K;
  localparam logic [HT_W-1:0] HUE_OFF360 = HT_W'(360) << HUE_K;

  logic [NSTEP-1:0] sat_sum;
  logic [HT_W-1:0]  y;
  logic             inexact;
  logic [HT_W-1:0]  base;
  logic [HT_W-1:0]  t;
  logic [HT_W-1:0]  hsum;
  logic [HT_W-1:0]  hr;
  logic [HUE_W-1:0] hue_d;
  logic [SAT_W-1:0] sat_d;
  logic             valid_q;
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;
  logic [CH_W-1:0]  val_q;

  always_comb begin
    sat_sum = stage_i.sat.nq + NSTEP'(1);
    sat_d   = stage_i.side.mz ? '0 : sat_sum[NSTEP-1:1];

    y       = HT_W'(stage_i.hue.nq);
    inexact = |stage_i.hue.rem;

    unique case (stage_i.side.sect)
      SECT_RED:   base = stage_i.side.neg ? HUE_OFF360 : '0;
      SECT_GREEN: base = HUE_OFF120;
      SECT_BLUE:  base = HUE_OFF240;
      default:    base = '0;
    endcase

    // A negative term rounds toward minus infinity, so a nonzero remainder takes one more.
    t     = stage_i.side.neg ? (base - y - HT_W'(inexact)) : (base + y);
    hsum  = t + HT_W'(1);
    hr    = hsum >> 1;
    hue_d = (stage_i.side.dz || hr >= HUE_FULL) ? '0 : HUE_W'(hr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= stage_i.side.mx;
    end
  end

  assign valid_o           = valid_q;
  assign hue_angle_o       = hue_q;
  assign saturation_frac_o = sat_q;
  assign value_level_o     = val_q;

`ifndef ASSERT_OFF
  a_sat_at_most_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> sat_q <= SAT_ONE)
    else $error("saturation above one");

  a_black_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && val_q == '0 |-> sat_q == '0 && hue_q == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey_sat_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_i.valid && stage_i.side.dz && !stage_i.side.mz |-> stage_i.sat.nq == '0)
    else $error("grey pixel with nonzero saturation quotient");
`endif

endmodule

FILE: src/rgb_to_hsv_converter.sv
// Channel  Role    Payload                                        Handshake
// pix_i    sink    red, green, blue (8 bits each)                 valid / ready
// hsv_o    source  hue_angle (15), saturation_frac (17),          valid / ready
//                  value_level (8)
//
// A new request is taken every cycle unless hsv_o stalls, so requests overlap in the pipe.
// The pipe has one setup stage, one cell per quotient bit (18 cells) and one result stage.
// Every stage advances together, so a stall at hsv_o holds the whole pipe and pix_i.ready.
// pix_i.ready follows hsv_o.ready in the same cycle whenever a result is waiting.
// Reset clears only the valid bits of the stages.
module rgb_to_hsv_converter import rgbhsv_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  rgbhsv_pix_if.sink  pix_i,
  rgbhsv_hsv_if.source hsv_o
);

  stage_t chain [NSTEP+1];
  logic   en;

  assign en          = !hsv_o.valid || hsv_o.ready;
  assign pix_i.ready = en;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  rgbhsv_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .stage_i           (chain[NSTEP]),
    .valid_o           (hsv_o.valid),
    .hue_angle_o       (hsv_o.hue_angle),
    .saturation_frac_o (hsv_o.saturation_frac),
    .value_level_o     (hsv_o.value_level)
  );

endmodule

FILE: tb/rgb_to_hsv_converter_tb.sv
module rgb_to_hsv_converter_tb import rgbhsv_pkg::*; ();

  typedef struct {
    logic [HUE_W-1:0] hue_angle;
    logic [SAT_W-1:0] saturation_frac;
    logic [CH_W-1:0]  value_level;
  } hsv_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rgbhsv_pix_if pix ();
  rgbhsv_hsv_if hsv ();

  rgb_to_hsv_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  hsv_pixel_t expected_hsv_q[$];
  int unsigned mismatch_count = 0;
  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("rgb_to_hsv_converter_tb failed");
    $finish;
  end

  function automatic hsv_pixel_t convert_rgb(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                             logic [CH_W-1:0] b);
    hsv_pixel_t res;
    longint mx;
    longint mn;
    longint d;
    longint deg_d;
    longint hue;
    longint scale;
    sect_e sect;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    scale = longint'(1) << HUE_FRAC_BITS;
    res.value_level = mx[CH_W-1:0];
    res.saturation_frac = '0;
    res.hue_angle = '0;
    if (mx != 0) begin
      res.saturation_frac = SAT_W'((2 * (d << 16) + mx) / (2 * mx));
    end
    if (d != 0) begin
      if (mx == r) sect = SECT_RED;
      else if (mx == g) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED: begin
          deg_d = 60 * (longint'(g) - longint'(b));
          if (deg_d < 0) deg_d += 360 * d;
        end
        SECT_GREEN: begin
          deg_d = 120 * d + 60 * (longint'(b) - longint'(r));
        end
        default: begin
          deg_d = 240 * d + 60 * (longint'(r) - longint'(g));
        end
      endcase
      hue = (2 * deg_d * scale + d) / (2 * d);
      if (hue >= 360 * scale) hue = 0;
      res.hue_angle = HUE_W'(hue);
    end
    return res;
  endfunction

  // Each call starts at a rising edge and returns at the edge where the request is taken.
  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    int unsigned gap;
    gap = send_gaps_on ? $urandom_range(0, 17) : 0;
    repeat (gap) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red <= r;
    pix.green <= g;
    pix.blue <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    expected_hsv_q.push_back(convert_rgb(r, g, b));
  endtask

  always @(posedge clk_i) begin
    if (hsv.valid && hsv.ready) begin
      if (expected_hsv_q.size() == 0) begin
        $error("unexpected result: hue_angle %0d saturation_frac %0d value_level %0d",
               hsv.hue_angle, hsv.saturation_frac, hsv.value_level);
        mismatch_count++;
      end else begin
        hsv_pixel_t exp_hsv;
        exp_hsv = expected_hsv_q.pop_front();
        if (hsv.hue_angle !== exp_hsv.hue_angle) begin
          $error("hue_angle: expected %0d, actual %0d", exp_hsv.hue_angle, hsv.hue_angle);
          mismatch_count++;
        end
        if (hsv.saturation_frac !== exp_hsv.saturation_frac) begin
          $error("saturation_frac: expected %0d, actual %0d", exp_hsv.saturation_frac,
                 hsv.saturation_frac);
          mismatch_count++;
        end
        if (hsv.value_level !== exp_hsv.value_level) begin
          $error("value_level: expected %0d, actual %0d", exp_hsv.value_level,
                 hsv.value_level);
          mismatch_count++;
        end
      end
    end
  end

  // The receiver stalls for a random number of cycles before each result it takes.
  initial begin
    int unsigned stall;
    hsv.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_stalls_on ? $urandom_range(0, 17) : 0;
      repeat (stall) begin
        hsv.ready <= 1'b0;
        @(posedge clk_i);
      end
      hsv.ready <= 1'b1;
      @(posedge clk_i);
      while (!hsv.valid) @(posedge clk_i);
    end
  end

  task automatic test_grey_and_black();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
  endtask

  task automatic test_primary_sectors();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd50, 8'd120);
    send_pixel(8'd30, 8'd220, 8'd90);
    send_pixel(8'd10, 8'd170, 8'd250);
  endtask

  // Equal maxima pick red over green and green over blue.
  task automatic test_max_ties();
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd100, 8'd100, 8'd99);
    send_pixel(8'd7, 8'd9, 8'd9);
  endtask

  // A red maximum with blue above green wraps to a hue below a full turn.
  task automatic test_hue_wrap();
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd2, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd85, 8'd170, 8'd255);
  endtask

  task automatic test_random_pixels(int unsigned count);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] edge_vals[4];
    edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        send_gaps_on = ($urandom_range(0, 3) != 0);
        recv_stalls_on = ($urandom_range(0, 3) != 0);
      end
      r = CH_W'($urandom_range(0, 255));
      g = CH_W'($urandom_range(0, 255));
      b = CH_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        6: begin
          g = r;
          b = r;
        end
        7: begin
          r = edge_vals[$urandom_range(0, 3)];
          g = edge_vals[$urandom_range(0, 3)];
          b = edge_vals[$urandom_range(0, 3)];
        end
        8: begin
          g = (r > 252) ? r - CH_W'($urandom_range(0, 3)) : r + CH_W'($urandom_range(0, 3));
          b = (r < 3) ? r + CH_W'($urandom_range(0, 3)) : r - CH_W'($urandom_range(0, 3));
        end
        9: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    send_gaps_on = 1'b0;
    recv_stalls_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                 CH_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    pix.valid <= 1'b0;
    pix.red <= '0;
    pix.green <= '0;
    pix.blue <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_grey_and_black();
    test_primary_sectors();
    test_max_ties();
    test_hue_wrap();
    test_random_pixels(380);
    test_back_to_back(50);
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    test_random_pixels(20);

    pix.valid <= 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rgb_to_hsv_converter_tb passed");
    end else begin
      $display("rgb_to_hsv_converter_tb failed");
    end
    $finish;
  end

endmodule
